>>> rtl/core/qp_pkg.sv
// Shared types, widths, codes and the CORDIC arctangent table for the
// quaternion pose to camera block. No dependencies.
package qp_pkg;

    localparam int QW          = 16;   // quaternion component width
    localparam int TW          = 32;   // translation width
    localparam int VW          = 32;   // result value width
    localparam int KW          = 3;    // result kind width
    localparam int RW          = 24;   // rotation entry width, Q16.16
    localparam int NW          = 34;   // square root radicand width
    localparam int ISQ_BITS    = 17;   // square root result bits, one per stage
    localparam int CW          = 34;   // CORDIC datapath width
    localparam int ZW          = 20;   // CORDIC angle width
    localparam int ATAN_LEN    = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ZW-1:0] HALF_PI = 20'sd102944;

    // Result kinds
    localparam logic [KW-1:0] ROW_COL0   = 3'd0;
    localparam logic [KW-1:0] ROW_COL1   = 3'd1;
    localparam logic [KW-1:0] ROW_COL2   = 3'd2;
    localparam logic [KW-1:0] ROW_CENTRE = 3'd3;
    localparam logic [KW-1:0] ROW_ANGLE  = 3'd4;

    // Cycles the command port stays busy after each accepted transaction
    localparam logic [2:0] GAP = 3'd4;

    typedef logic [2:0][VW-1:0] vec3_t;

    typedef struct packed {
        logic [2:0][2:0][VW-1:0] col;   // col[k][j]: column k, entry j
        vec3_t                   cen;
        logic                    p_pos;
        logic                    p_neg;
    } side_t;

    typedef struct packed {
        logic signed [RW-1:0] r20;
        logic signed [RW-1:0] r22;
        logic signed [RW-1:0] s;
    } ang_t;

    // Arctangent of 2^-i in Q16.16
    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 20'sd51472;
            1:       a = 20'sd30385;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            16:      a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/qp_front.sv
// Front pipeline: quaternion products, rotation matrix, rotated columns,
// camera centre and the radicand for pitch. Depends on qp_pkg.
module qp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [qp_pkg::QW-1:0] qw,
    input  logic signed [qp_pkg::QW-1:0] qx,
    input  logic signed [qp_pkg::QW-1:0] qy,
    input  logic signed [qp_pkg::QW-1:0] qz,
    input  logic signed [qp_pkg::TW-1:0] tx,
    input  logic signed [qp_pkg::TW-1:0] ty,
    input  logic signed [qp_pkg::TW-1:0] tz,
    output logic                        out_valid,
    output qp_pkg::side_t               side,
    output qp_pkg::ang_t                ang,
    output logic [qp_pkg::NW-1:0]       rad
);

    // Round half up of a Q2.28 value to Q16.16
    function automatic logic signed [qp_pkg::RW-1:0] rnd12(input logic signed [33:0] v);
        logic signed [35:0] t;
        t = 36'(v) + 36'sd2048;
        return t[35:12];
    endfunction

    function automatic logic signed [qp_pkg::RW-1:0] diag(input logic signed [31:0] a,
                                                          input logic signed [31:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        return rnd12((34'sd1 <<< 28) - (s <<< 1));
    endfunction

    function automatic logic signed [qp_pkg::RW-1:0] off(input logic signed [31:0] a,
                                                         input logic signed [31:0] b,
                                                         input logic sub);
        logic signed [33:0] s;
        s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
        return rnd12(s <<< 1);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic signed [qp_pkg::TW-1:0] t1_reg [0:2];
    logic signed [qp_pkg::TW-1:0] t2_reg [0:2];
    logic signed [qp_pkg::RW-1:0] r_reg [0:2][0:2];
    logic signed [55:0] m_reg [0:2][0:2];
    logic [2:0][2:0][qp_pkg::VW-1:0] col3_reg, col4_reg;
    qp_pkg::ang_t ang3_reg, ang4_reg;
    logic pos3_reg, neg3_reg, pos4_reg, neg4_reg;
    logic signed [35:0] sq_reg;
    qp_pkg::vec3_t cen_reg;
    logic [qp_pkg::NW-1:0] rad_reg;

    logic signed [qp_pkg::RW-1:0] r_next [0:2][0:2];
    logic signed [qp_pkg::RW-1:0] s3;
    logic signed [17:0] s18;
    qp_pkg::vec3_t cen_next;
    logic signed [57:0] dsum;
    logic signed [57:0] drnd;
    logic signed [42:0] dq;
    logic signed [42:0] de;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Form the rotation entries from the products
    always_comb
    begin
        r_next[0][0] = diag(yy_reg, zz_reg);
        r_next[0][1] = off(xy_reg, wz_reg, 1'b1);
        r_next[0][2] = off(xz_reg, wy_reg, 1'b0);
        r_next[1][0] = off(xy_reg, wz_reg, 1'b0);
        r_next[1][1] = diag(xx_reg, zz_reg);
        r_next[1][2] = off(yz_reg, wx_reg, 1'b1);
        r_next[2][0] = off(xz_reg, wy_reg, 1'b1);
        r_next[2][1] = off(yz_reg, wx_reg, 1'b0);
        r_next[2][2] = diag(xx_reg, yy_reg);
    end

    assign s3  = -r_reg[2][1];
    assign s18 = s3[17:0];

    // Sum, round and saturate the centre, negating x and z
    always_comb
    begin
        dsum = '0;
        drnd = '0;
        dq   = '0;
        de   = '0;
        cen_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            dsum = 58'(m_reg[0][j]) + 58'(m_reg[1][j]) + 58'(m_reg[2][j]);
            drnd = dsum + 58'sd32768;
            dq   = {drnd[57], drnd[57:16]};
            de   = (j == 1) ? dq : -dq;
            if (de > 43'sd2147483647)
                cen_next[j] = 32'h7fff_ffff;
            else if (de < -43'sd2147483648)
                cen_next[j] = 32'h8000_0000;
            else
                cen_next[j] = de[31:0];
        end
    end

    // Stage data registers
    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        wx_reg <= qw * qx;
        wy_reg <= qw * qy;
        wz_reg <= qw * qz;
        t1_reg[0] <= tx;
        t1_reg[1] <= ty;
        t1_reg[2] <= tz;

        for (int i = 0; i < 3; i++)
        begin
            t2_reg[i] <= t1_reg[i];
            for (int j = 0; j < 3; j++)
            begin
                r_reg[i][j] <= r_next[i][j];
                m_reg[i][j] <= 56'(r_reg[i][j]) * 56'(t2_reg[i]);
            end
        end

        for (int j = 0; j < 3; j++)
        begin
            col3_reg[0][j] <= 32'(r_reg[j][0]);
            col3_reg[1][j] <= -(32'(r_reg[j][1]));
            col3_reg[2][j] <= 32'(r_reg[j][2]);
        end
        ang3_reg.r20 <= r_reg[2][0];
        ang3_reg.r22 <= r_reg[2][2];
        ang3_reg.s   <= s3;
        pos3_reg <= (s3 >= 24'sd65536);
        neg3_reg <= (s3 <= -24'sd65536);
        sq_reg   <= s18 * s18;

        col4_reg <= col3_reg;
        ang4_reg <= ang3_reg;
        pos4_reg <= pos3_reg;
        neg4_reg <= neg3_reg;
        cen_reg  <= cen_next;
        rad_reg  <= 34'h1_0000_0000 - 34'(sq_reg[33:0]);
    end

    assign out_valid  = v4_reg;
    assign side.col   = col4_reg;
    assign side.cen   = cen_reg;
    assign side.p_pos = pos4_reg;
    assign side.p_neg = neg4_reg;
    assign ang        = ang4_reg;
    assign rad        = rad_reg;

endmodule

>>> rtl/core/qp_delay.sv
// Fixed-depth delay line for a valid bit and a data word.
// No package dependencies.
module qp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             v_reg [0:DEPTH-1];
    logic [WIDTH-1:0] d_reg [0:DEPTH-1];

    // Shift valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // Shift data
    always_ff @(posedge clk)
    begin
        d_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
            d_reg[i] <= d_reg[i-1];
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = d_reg[DEPTH-1];

endmodule

>>> rtl/core/qp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qp_pkg.
module qp_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [qp_pkg::NW-1:0]         rad,
    output logic                          out_valid,
    output logic [qp_pkg::ISQ_BITS-1:0]   root
);

    localparam int N = qp_pkg::ISQ_BITS;

    logic                  v_s    [0:N];
    logic [19:0]           rem_s  [0:N];
    logic [N-1:0]          root_s [0:N];
    logic [qp_pkg::NW-1:0] nsh_s  [0:N];

    assign v_s[0]    = in_valid;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign nsh_s[0]  = rad;

    for (genvar g = 0; g < N; g++)
    begin : g_stage
        logic [19:0] cat;
        logic [19:0] trial;
        logic        take;

        // Bring down two radicand bits and try the next root bit
        assign cat   = {rem_s[g][17:0], nsh_s[g][qp_pkg::NW-1 -: 2]};
        assign trial = {1'b0, root_s[g], 2'b01};
        assign take  = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_s[g+1] <= 1'b0;
            else
                v_s[g+1] <= v_s[g];
        end

        always_ff @(posedge clk)
        begin
            rem_s[g+1]  <= take ? (cat - trial) : cat;
            root_s[g+1] <= {root_s[g][N-2:0], take};
            nsh_s[g+1]  <= {nsh_s[g][qp_pkg::NW-3:0], 2'b00};
        end
    end

    assign out_valid = v_s[N];
    assign root      = root_s[N];

endmodule

>>> rtl/core/qp_cordic.sv
// Pipelined vectoring CORDIC for atan2(y, x) in Q16.16: one pre-rotation
// stage, then one stage per iteration. Depends on qp_pkg.
module qp_cordic #(
    parameter int STEPS = qp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [qp_pkg::RW-1:0]  y_in,
    input  logic signed [qp_pkg::RW-1:0]  x_in,
    output logic                          out_valid,
    output logic signed [qp_pkg::ZW-1:0]  angle
);

    localparam int USED = (STEPS < qp_pkg::ATAN_LEN) ? STEPS : qp_pkg::ATAN_LEN;
    localparam int CW   = qp_pkg::CW;
    localparam int ZW   = qp_pkg::ZW;

    logic                 v_s    [0:USED];
    logic                 zero_s [0:USED];
    logic signed [CW-1:0] x_s    [0:USED];
    logic signed [CW-1:0] y_s    [0:USED];
    logic signed [ZW-1:0] z_s    [0:USED];

    logic signed [CW-1:0] xs, ys;

    assign xs = CW'(x_in) <<< 8;
    assign ys = CW'(y_in) <<< 8;

    // Pre-rotate into the right half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_s[0] <= 1'b0;
        else
            v_s[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        zero_s[0] <= (x_in == '0) && (y_in == '0);
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x_s[0] <= ys;
                y_s[0] <= -xs;
                z_s[0] <= qp_pkg::HALF_PI;
            end
            else
            begin
                x_s[0] <= -ys;
                y_s[0] <= xs;
                z_s[0] <= -qp_pkg::HALF_PI;
            end
        end
        else
        begin
            x_s[0] <= xs;
            y_s[0] <= ys;
            z_s[0] <= '0;
        end
    end

    for (genvar g = 0; g < USED; g++)
    begin : g_step
        logic signed [CW-1:0] dx, dy;

        assign dx = y_s[g] >>> g;
        assign dy = x_s[g] >>> g;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_s[g+1] <= 1'b0;
            else
                v_s[g+1] <= v_s[g];
        end

        // Rotate towards the x axis
        always_ff @(posedge clk)
        begin
            zero_s[g+1] <= zero_s[g];
            if (y_s[g] >= 0)
            begin
                x_s[g+1] <= x_s[g] + dx;
                y_s[g+1] <= y_s[g] - dy;
                z_s[g+1] <= z_s[g] + qp_pkg::atan_q16(g);
            end
            else
            begin
                x_s[g+1] <= x_s[g] - dx;
                y_s[g+1] <= y_s[g] + dy;
                z_s[g+1] <= z_s[g] - qp_pkg::atan_q16(g);
            end
        end
    end

    assign out_valid = v_s[USED];
    assign angle     = zero_s[USED] ? '0 : z_s[USED];

endmodule

>>> rtl/core/qp_emit.sv
// Result serialiser: holds the five results of one pose and sends them
// one per cycle. Depends on qp_pkg.
module qp_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  qp_pkg::side_t                 side,
    input  logic signed [qp_pkg::ZW-1:0]  yaw,
    input  logic signed [qp_pkg::ZW-1:0]  pitch,
    output logic                          strobe,
    output logic [qp_pkg::KW-1:0]         row_kind,
    output logic signed [qp_pkg::VW-1:0]  val_a,
    output logic signed [qp_pkg::VW-1:0]  val_b,
    output logic signed [qp_pkg::VW-1:0]  val_c,
    output logic                          last
);

    logic [4:0][2:0][qp_pkg::VW-1:0] hold_reg;
    logic [qp_pkg::KW-1:0]           cnt_reg, cnt_next;
    logic                            act_reg, act_next;
    logic signed [qp_pkg::ZW-1:0]    pitch_sel;

    // Saturate pitch outside the arcsine range
    always_comb
    begin
        if (side.p_pos)
            pitch_sel = qp_pkg::HALF_PI;
        else if (side.p_neg)
            pitch_sel = -qp_pkg::HALF_PI;
        else
            pitch_sel = pitch;
    end

    // Step through the held results
    always_comb
    begin
        cnt_next = cnt_reg;
        act_next = act_reg;
        if (in_valid)
        begin
            cnt_next = qp_pkg::ROW_COL0;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (cnt_reg == qp_pkg::ROW_ANGLE)
                act_next = 1'b0;
            else
                cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= qp_pkg::ROW_COL0;
            act_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            act_reg <= act_next;
        end
    end

    // Capture a finished pose; entry 0 of each row is val_a
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            hold_reg[qp_pkg::ROW_COL0]   <= side.col[0];
            hold_reg[qp_pkg::ROW_COL1]   <= side.col[1];
            hold_reg[qp_pkg::ROW_COL2]   <= side.col[2];
            hold_reg[qp_pkg::ROW_CENTRE] <= side.cen;
            hold_reg[qp_pkg::ROW_ANGLE]  <= {32'd0, 32'(pitch_sel), 32'(yaw)};
        end
    end

    assign strobe   = act_reg;
    assign row_kind = cnt_reg;
    assign val_a    = hold_reg[cnt_reg][0];
    assign val_b    = hold_reg[cnt_reg][1];
    assign val_c    = hold_reg[cnt_reg][2];
    assign last     = (cnt_reg == qp_pkg::ROW_ANGLE);

endmodule

>>> rtl/core/quaternion_pose_to_camera.sv
// Top level of the quaternion pose to camera block.
// Depends on qp_pkg, qp_front, qp_delay, qp_isqrt, qp_cordic and qp_emit.
//
// A pose is accepted at a clock edge where start is high and busy is low;
// busy then stays high, and no further pose is taken until it is low
// again. Each pose yields five results, one per cycle on consecutive
// cycles, each shown for exactly one cycle with strobe high: rotation
// columns 0, 1 (negated) and 2, the camera centre, then yaw and pitch;
// last marks the fifth. The receiver cannot hold results off and must
// take one every cycle while strobe is high. Each pose passes through
// the four-stage matrix front end, the 17-stage square root, the
// one-stage-per-iteration CORDIC pipeline and the result serialiser.
module quaternion_pose_to_camera #(
    parameter int CORDIC_STEPS = qp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [qp_pkg::QW-1:0]  quat_w,
    input  logic signed [qp_pkg::QW-1:0]  quat_x,
    input  logic signed [qp_pkg::QW-1:0]  quat_y,
    input  logic signed [qp_pkg::QW-1:0]  quat_z,
    input  logic signed [qp_pkg::TW-1:0]  trans_x,
    input  logic signed [qp_pkg::TW-1:0]  trans_y,
    input  logic signed [qp_pkg::TW-1:0]  trans_z,
    output logic                          strobe,
    output logic [qp_pkg::KW-1:0]         row_kind,
    output logic signed [qp_pkg::VW-1:0]  val_a,
    output logic signed [qp_pkg::VW-1:0]  val_b,
    output logic signed [qp_pkg::VW-1:0]  val_c,
    output logic                          last
);

    localparam int USED = (CORDIC_STEPS < qp_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                            : qp_pkg::ATAN_LEN;
    localparam int CORDIC_LAT = USED + 1;
    localparam int SIDE_LAT   = qp_pkg::ISQ_BITS + CORDIC_LAT;

    logic [2:0] gap_reg, gap_next;
    logic       accept;

    logic                          f_valid;
    qp_pkg::side_t                 f_side;
    qp_pkg::ang_t                  f_ang;
    logic [qp_pkg::NW-1:0]         f_rad;

    logic                          a_valid;
    qp_pkg::ang_t                  a_ang;
    logic                          r_valid;
    logic [qp_pkg::ISQ_BITS-1:0]   r_root;
    logic                          s_valid;
    qp_pkg::side_t                 s_side;
    logic                          y_valid, p_valid;
    logic signed [qp_pkg::ZW-1:0]  yaw_z, pitch_z;

    // Throttle the command port: no new transaction is taken while busy is high
    assign accept = start && !busy;
    assign busy   = (gap_reg != 3'd0);

    always_comb
    begin
        if (accept)
            gap_next = qp_pkg::GAP;
        else if (gap_reg != 3'd0)
            gap_next = gap_reg - 3'd1;
        else
            gap_next = gap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= 3'd0;
        else
            gap_reg <= gap_next;
    end

    qp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .qw        (quat_w),
        .qx        (quat_x),
        .qy        (quat_y),
        .qz        (quat_z),
        .tx        (trans_x),
        .ty        (trans_y),
        .tz        (trans_z),
        .out_valid (f_valid),
        .side      (f_side),
        .ang       (f_ang),
        .rad       (f_rad)
    );

    // Hold the angle inputs level with the square root
    qp_delay #(
        .WIDTH ($bits(qp_pkg::ang_t)),
        .DEPTH (qp_pkg::ISQ_BITS)
    ) u_ang_dly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_data   (f_ang),
        .out_valid (a_valid),
        .out_data  (a_ang)
    );

    qp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .rad       (f_rad),
        .out_valid (r_valid),
        .root      (r_root)
    );

    qp_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .y_in      (a_ang.r20),
        .x_in      (a_ang.r22),
        .out_valid (y_valid),
        .angle     (yaw_z)
    );

    qp_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .y_in      (a_ang.s),
        .x_in      (qp_pkg::RW'(r_root)),
        .out_valid (p_valid),
        .angle     (pitch_z)
    );

    // Hold columns and centre until the angles are ready
    qp_delay #(
        .WIDTH ($bits(qp_pkg::side_t)),
        .DEPTH (SIDE_LAT)
    ) u_side_dly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_data   (f_side),
        .out_valid (s_valid),
        .out_data  (s_side)
    );

    qp_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_valid && y_valid && p_valid),
        .side     (s_side),
        .yaw      (yaw_z),
        .pitch    (pitch_z),
        .strobe   (strobe),
        .row_kind (row_kind),
        .val_a    (val_a),
        .val_b    (val_b),
        .val_c    (val_c),
        .last     (last)
    );

endmodule

>>> bench/quaternion_pose_to_camera_test.sv
// Self-checking bench for quaternion_pose_to_camera: directed and random poses,
// predicted column, centre and angle transactions checked field by field.
// Depends on qp_pkg and the quaternion_pose_to_camera RTL.
module quaternion_pose_to_camera_test;

    localparam int  STEPS       = qp_pkg::CORDIC_STEPS_DEF;
    localparam int  N_RANDOM    = 300;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  DRAIN_WAIT  = 22 + STEPS + 20;

    typedef struct {
        logic signed [qp_pkg::QW-1:0] w, x, y, z;
        logic signed [qp_pkg::TW-1:0] tx, ty, tz;
    } pose_t;

    typedef struct {
        logic [qp_pkg::KW-1:0]        kind;
        logic signed [qp_pkg::VW-1:0] a, b, c;
        logic                         fin;
    } frame_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [qp_pkg::QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [qp_pkg::TW-1:0] trans_x = '0, trans_y = '0, trans_z = '0;
    logic                         strobe;
    logic [qp_pkg::KW-1:0]        row_kind;
    logic signed [qp_pkg::VW-1:0] val_a, val_b, val_c;
    logic                         last;

    pose_t  pose_q[$];
    frame_t frame_q[$];
    int     errors = 0;
    int     poses_sent = 0;
    int     frames_seen = 0;
    int     idle_cycles = 0;
    int     burst_left = 4;
    int     gap_left = 0;
    bit     feeding_done = 1'b0;

    longint atan_lut[qp_pkg::ATAN_LEN] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    quaternion_pose_to_camera u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
        .strobe(strobe), .row_kind(row_kind), .val_a(val_a), .val_b(val_b),
        .val_c(val_c), .last(last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Round half up after dropping s fraction bits
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= r + bitv)
            begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC arctangent, angle in Q16.16
    function automatic longint vector_angle(longint y, longint x);
        longint ang, t, dx, dy;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                ang = longint'(qp_pkg::HALF_PI);
            end
            else
            begin
                x = -y;
                y = t;
                ang = -longint'(qp_pkg::HALF_PI);
            end
        end
        for (int i = 0; i < STEPS && i < qp_pkg::ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                ang += atan_lut[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                ang -= atan_lut[i];
            end
        end
        return ang;
    endfunction

    // Work out the five transactions one pose causes and queue them
    task automatic predict_frames(pose_t p);
        longint w, x, y, z, tx, ty, tz, one, d, s, pitch;
        longint rm[3][3];
        longint v[5][3];
        frame_t f;
        w = p.w; x = p.x; y = p.y; z = p.z;
        tx = p.tx; ty = p.ty; tz = p.tz;
        one = longint'(1) << 28;
        rm[0][0] = round_shift(one - 2 * (y * y + z * z), 12);
        rm[0][1] = round_shift(2 * (x * y - w * z), 12);
        rm[0][2] = round_shift(2 * (x * z + w * y), 12);
        rm[1][0] = round_shift(2 * (x * y + w * z), 12);
        rm[1][1] = round_shift(one - 2 * (x * x + z * z), 12);
        rm[1][2] = round_shift(2 * (y * z - w * x), 12);
        rm[2][0] = round_shift(2 * (x * z - w * y), 12);
        rm[2][1] = round_shift(2 * (y * z + w * x), 12);
        rm[2][2] = round_shift(one - 2 * (x * x + y * y), 12);
        for (int j = 0; j < 3; j++)
        begin
            v[0][j] = rm[j][0];
            v[1][j] = -rm[j][1];
            v[2][j] = rm[j][2];
            d = round_shift(rm[0][j] * tx + rm[1][j] * ty + rm[2][j] * tz, 16);
            v[3][j] = clamp32(j == 1 ? d : -d);
        end
        v[4][0] = vector_angle(rm[2][0], rm[2][2]);
        s = -rm[2][1];
        if (s >= 65536)
            pitch = longint'(qp_pkg::HALF_PI);
        else if (s <= -65536)
            pitch = -longint'(qp_pkg::HALF_PI);
        else
            pitch = vector_angle(s, longint'(int_root((64'd1 << 32) - longint'(s * s))));
        v[4][1] = pitch;
        v[4][2] = 0;
        for (int k = 0; k < 5; k++)
        begin
            f.kind = (k == 0) ? qp_pkg::ROW_COL0 : (k == 1) ? qp_pkg::ROW_COL1 :
                     (k == 2) ? qp_pkg::ROW_COL2 : (k == 3) ? qp_pkg::ROW_CENTRE :
                     qp_pkg::ROW_ANGLE;
            f.a = 32'(clamp32(v[k][0]));
            f.b = 32'(clamp32(v[k][1]));
            f.c = 32'(clamp32(v[k][2]));
            f.fin = (k == 4);
            frame_q.push_back(f);
        end
    endtask

    task automatic add_pose(int w, int x, int y, int z, int tx, int ty, int tz);
        pose_t p;
        p.w = 16'(w); p.x = 16'(x); p.y = 16'(y); p.z = 16'(z);
        p.tx = tx; p.ty = ty; p.tz = tz;
        pose_q.push_back(p);
    endtask

    function automatic int rand_q14();
        return $urandom_range(32768, 0) - 16384;
    endfunction

    function automatic int rand_trans();
        if ($urandom_range(3, 0) == 0)
            return $urandom;
        return $urandom_range(2 ** 21, 0) - 2 ** 20;
    endfunction

    // Fill the pose queue: directed corners, then random poses
    initial
    begin
        real    cw, cx, cy, cz, nrm;
        int     kmax;
        kmax = 32'sh7fffffff;
        // identity, negated identity, centre at the limits and saturating upwards
        add_pose(16384, 0, 0, 0, 0, 0, 0);
        add_pose(-16384, 0, 0, 0, 65536, -65536, 131072);
        add_pose(16384, 0, 0, 0, kmax, -kmax - 1, kmax);
        add_pose(16384, 0, 0, 0, -kmax - 1, kmax, -kmax - 1);
        // half turns about each axis
        add_pose(0, 16384, 0, 0, 12345, -6789, 1000);
        add_pose(0, 0, 16384, 0, -1, 1, -1);
        add_pose(0, 0, 0, 16384, 7 << 16, 3 << 16, -5 << 16);
        add_pose(0, -16384, 0, 0, 0, 0, 0);
        add_pose(0, 0, -16384, 0, 0, 0, 0);
        add_pose(0, 0, 0, -16384, 0, 0, 0);
        // zero direction: yaw forced to zero; then the zero quaternion
        add_pose(0, 8192, 8192, 0, 1 << 16, 2 << 16, 3 << 16);
        add_pose(0, 0, 0, 0, 0, 0, 0);
        // pitch at and beyond both limits
        add_pose(16384, -8192, 0, 0, 0, 0, 0);
        add_pose(16384, 8192, 0, 0, 0, 0, 0);
        add_pose(16384, 16384, 0, 0, 0, 0, 0);
        add_pose(16384, -16384, 0, 0, 0, 0, 0);
        // non-unit quaternions with extreme translations, a tiny one, a quarter turn about y
        add_pose(16384, 16384, 16384, 16384, kmax, kmax, kmax);
        add_pose(-16384, -16384, -16384, -16384, -kmax - 1, -kmax - 1, -kmax - 1);
        add_pose(-16384, 16384, -16384, 16384, kmax, -kmax - 1, 0);
        add_pose(-1, -1, -1, -1, -1, -1, -1);
        add_pose(11585, 0, 11585, 0, 100 << 16, 0, -(100 << 16));
        // mostly unit quaternions with random content, the rest raw noise
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(9, 0) < 7)
            begin
                cw = rand_q14(); cx = rand_q14(); cy = rand_q14(); cz = rand_q14();
                nrm = $sqrt(cw * cw + cx * cx + cy * cy + cz * cz);
                if (nrm < 1.0)
                    nrm = 1.0;
                add_pose(int'($floor(cw * 16384.0 / nrm + 0.5)),
                         int'($floor(cx * 16384.0 / nrm + 0.5)),
                         int'($floor(cy * 16384.0 / nrm + 0.5)),
                         int'($floor(cz * 16384.0 / nrm + 0.5)),
                         rand_trans(), rand_trans(), rand_trans());
            end
            else
                add_pose(rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                         rand_trans(), rand_trans(), rand_trans());
        end
        feeding_done = 1'b1;
    end

    // Release reset once
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: present poses in bursts, hold each until the block takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            quat_w  <= '0;
            quat_x  <= '0;
            quat_y  <= '0;
            quat_z  <= '0;
            trans_x <= '0;
            trans_y <= '0;
            trans_z <= '0;
        end
        else if (start && busy)
        begin
            start <= 1'b1;
        end
        else
        begin
            if (start)
            begin
                predict_frames('{quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z});
                poses_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(12, 1);
                    gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(20, 1);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pose_q.size() > 0)
            begin
                pose_t p;
                p = pose_q.pop_front();
                start   <= 1'b1;
                quat_w  <= p.w;
                quat_x  <= p.x;
                quat_y  <= p.y;
                quat_z  <= p.z;
                trans_x <= p.tx;
                trans_y <= p.ty;
                trans_z <= p.tz;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each strobed transaction against the oldest prediction
    always @(posedge clk)
    begin
        frame_t f;
        if (rst_n && strobe)
        begin
            frames_seen++;
            if (frame_q.size() == 0)
            begin
                $error("unexpected transaction: row_kind %0d", row_kind);
                errors++;
            end
            else
            begin
                f = frame_q.pop_front();
                if (row_kind !== f.kind)
                begin
                    $error("row_kind: expected %0d, got %0d", f.kind, row_kind);
                    errors++;
                end
                if (val_a !== f.a)
                begin
                    $error("val_a: expected %0d, got %0d", f.a, val_a);
                    errors++;
                end
                if (val_b !== f.b)
                begin
                    $error("val_b: expected %0d, got %0d", f.b, val_b);
                    errors++;
                end
                if (val_c !== f.c)
                begin
                    $error("val_c: expected %0d, got %0d", f.c, val_c);
                    errors++;
                end
                if (last !== f.fin)
                begin
                    $error("last: expected %0d, got %0d", f.fin, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d transactions outstanding", frame_q.size());
            $display("** quaternion_pose_to_camera: FAILED **");
            $finish;
        end
    end

    // Wait for the queues to drain, let the pipeline settle, then report
    initial
    begin
        wait (rst_n && feeding_done);
        @(posedge clk);
        while (pose_q.size() > 0 || start || frame_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (frame_q.size() > 0)
        begin
            $error("%0d predicted transactions never arrived", frame_q.size());
            errors++;
        end
        $display("covered %0d poses (corners, limits, non-unit and random) and %0d results",
                 poses_sent, frames_seen);
        $display("%0d mismatches found", errors);
        if (errors == 0)
            $display("** quaternion_pose_to_camera: PASSED **");
        else
            $display("** quaternion_pose_to_camera: FAILED **");
        $finish;
    end

endmodule
